[rtl/core/prd_pkg.sv]
// Shared types and constants for the piece reassembly deframer.
package prd_pkg;

  // Sync pair that opens every piece header.
  localparam logic [7:0] SYNC_FIRST  = 8'hAF;
  localparam logic [7:0] SYNC_SECOND = 8'hAE;

  // Header byte positions; sync takes positions 0 and 1.
  localparam logic [15:0] HEADER_FIRST = 16'd2;
  localparam logic [15:0] HEADER_LAST  = 16'd9;
  localparam logic [3:0]  POS_TOTAL_SIZE   = 4'd3;
  localparam logic [3:0]  POS_TOTAL_PIECES = 4'd5;
  localparam logic [3:0]  POS_PIECE_INDEX  = 4'd7;

  // Frame status codes.
  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_LEN_ERR  = 2'd2;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // One result word.
  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        piece_done;
    logic [1:0]  frame_status;
    logic [15:0] piece_number;
  } prd_result_t;

endpackage

[rtl/core/piece_reassembly_deframer.sv]
// Top level of the piece reassembly deframer.
//
//   channel | ports                      | word
//   --------+----------------------------+-------------------------------------
//   input   | in_valid / in_stall        | in_rx_byte
//   result  | out_valid / out_stall      | out_write_valid, out_write_addr,
//           |                            | out_write_data, out_piece_done,
//           |                            | out_frame_status, out_piece_number
//
// One byte is taken per cycle while in_stall is low; a result appears once its
// byte has passed the input register and the parser's single pass has loaded
// the result register. Sync and header bytes give no result, except the last
// header byte of an empty piece; every payload byte gives one.
// Reset (synchronous, active low) returns the parser to sync hunt with no frame.
// A stalled result holds the result register; the input register still takes
// one more byte, and bytes without a result keep flowing.
module piece_reassembly_deframer
  import prd_pkg::*;
#(
  parameter int unsigned PIECE_BYTES = 1024
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_valid,
  output logic [15:0] out_write_addr,
  output logic [7:0]  out_write_data,
  output logic        out_piece_done,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_piece_number
);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        fire;
  logic        has_result;
  logic        out_free;
  prd_result_t result;
  prd_result_t held;

  // Input register.
  prd_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_byte   (in_rx_byte),
    .in_stall  (in_stall),
    .take      (fire),
    .item_valid(item_valid),
    .item_byte (item_byte)
  );

  // Parser and frame tracker.
  prd_parser #(
    .PIECE_BYTES(PIECE_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(item_valid),
    .item_byte (item_byte),
    .out_free  (out_free),
    .fire      (fire),
    .has_result(has_result),
    .result    (result)
  );

  // Result register.
  prd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire && has_result),
    .result   (result),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .held     (held)
  );

  assign out_write_valid  = held.write_valid;
  assign out_write_addr   = held.write_addr;
  assign out_write_data   = held.write_data;
  assign out_piece_done   = held.piece_done;
  assign out_frame_status = held.frame_status;
  assign out_piece_number = held.piece_number;

endmodule

[rtl/core/prd_in_reg.sv]
// Input register stage for received bytes.
module prd_in_reg
  import prd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // A new word can enter when the stage is empty or is being consumed.
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;

endmodule

[rtl/core/prd_parser.sv]
// Sync hunt, header parse, frame tracking and result formation.
module prd_parser
  import prd_pkg::*;
#(
  parameter int unsigned PIECE_BYTES = 1024
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [7:0]  item_byte,
  input  logic        out_free,
  output logic        fire,
  output logic        has_result,
  output prd_result_t result
);

  localparam int unsigned PROD_W = 16 + $clog2(PIECE_BYTES + 1);
  localparam int unsigned ADDR_W = PROD_W + 1;
  localparam logic [PROD_W-1:0] PIECE_BYTES_W = PROD_W'(PIECE_BYTES);

  phase_t              phase_r, phase_nxt;
  logic [15:0]         pos_r, pos_nxt;
  logic                sync1_r, sync1_nxt;
  logic [7:0]          high_r, high_nxt;
  logic [15:0]         hts_r, hts_nxt;
  logic [15:0]         htp_r, htp_nxt;
  logic [15:0]         hidx_r, hidx_nxt;
  logic [15:0]         hlen_r, hlen_nxt;
  logic [15:0]         fts_r, fts_nxt;
  logic [15:0]         ftp_r, ftp_nxt;
  logic [15:0]         pr_r, pr_nxt;
  logic [23:0]         br_r, br_nxt;
  logic [PROD_W-1:0]   base_r;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  logic [15:0] hdr_word;
  logic        adopt;
  logic [15:0] fts_a, ftp_a, pr_a;
  logic [23:0] br_a;
  logic        restart;
  logic [15:0] fts_b, ftp_b, pr_b;
  logic [23:0] br_b;
  logic [23:0] br_inc;
  logic        off_last;
  logic        keep;

  // Header word assembled from the held high byte and the current byte.
  assign hdr_word = {high_r, item_byte};

  // Frame bookkeeping at the end of a header: adopt totals if no frame is open,
  // count the piece, and restart the frame if the totals changed.
  assign adopt   = (fts_r == 16'd0);
  assign fts_a   = adopt ? hts_r : fts_r;
  assign ftp_a   = adopt ? htp_r : ftp_r;
  assign pr_a    = adopt ? 16'd0 : pr_r;
  assign br_a    = adopt ? 24'd0 : br_r;
  assign restart = (hts_r != fts_a) || (htp_r != ftp_a);
  assign fts_b   = restart ? hts_r : fts_a;
  assign ftp_b   = restart ? htp_r : ftp_a;
  assign pr_b    = restart ? 16'd1 : pr_a + 16'd1;
  assign br_b    = restart ? 24'd0 : br_a;

  // Payload byte helpers: saturating byte count, last-byte test, range check.
  assign br_inc   = (br_r != 24'hFFFFFF) ? br_r + 24'd1 : br_r;
  assign off_last = ({1'b0, pos_r} + 17'd1) >= {1'b0, hlen_r};
  assign keep     = addr_r < ADDR_W'(fts_r);

  // Next state and result for the word in the input register.
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sync1_nxt  = sync1_r;
    high_nxt   = high_r;
    hts_nxt    = hts_r;
    htp_nxt    = htp_r;
    hidx_nxt   = hidx_r;
    hlen_nxt   = hlen_r;
    fts_nxt    = fts_r;
    ftp_nxt    = ftp_r;
    pr_nxt     = pr_r;
    br_nxt     = br_r;
    addr_nxt   = addr_r;
    has_result = 1'b0;
    result     = '0;
    case (phase_r)
      PH_HEADER: begin
        if (!pos_r[0]) begin
          high_nxt = item_byte;
        end else begin
          case (pos_r[3:0])
            POS_TOTAL_SIZE:   hts_nxt  = hdr_word;
            POS_TOTAL_PIECES: htp_nxt  = hdr_word;
            POS_PIECE_INDEX:  hidx_nxt = hdr_word;
            default:          hlen_nxt = hdr_word;
          endcase
        end
        if (pos_r < HEADER_LAST) begin
          pos_nxt = pos_r + 16'd1;
        end else begin
          fts_nxt  = fts_b;
          ftp_nxt  = ftp_b;
          pr_nxt   = pr_b;
          br_nxt   = br_b;
          addr_nxt = ADDR_W'(base_r);
          pos_nxt  = 16'd0;
          if (hdr_word == 16'd0) begin
            // A zero-length piece ends with its header.
            has_result          = 1'b1;
            result.piece_done   = 1'b1;
            result.piece_number = hidx_r;
            if (pr_b == ftp_b) begin
              ftp_nxt = 16'd0;
              pr_nxt  = 16'd0;
              result.frame_status = (br_b == {8'd0, fts_b}) ? ST_COMPLETE : ST_LEN_ERR;
            end
            phase_nxt = PH_HUNT;
            sync1_nxt = 1'b0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        has_result          = 1'b1;
        br_nxt              = br_inc;
        addr_nxt            = addr_r + ADDR_W'(1);
        result.write_valid  = keep;
        result.write_addr   = keep ? addr_r[15:0] : 16'd0;
        result.write_data   = keep ? item_byte : 8'd0;
        result.piece_number = hidx_r;
        if (off_last) begin
          result.piece_done = 1'b1;
          if (pr_r == ftp_r) begin
            ftp_nxt = 16'd0;
            pr_nxt  = 16'd0;
            result.frame_status = (br_inc == {8'd0, fts_r}) ? ST_COMPLETE : ST_LEN_ERR;
          end
          phase_nxt = PH_HUNT;
          sync1_nxt = 1'b0;
          pos_nxt   = 16'd0;
        end else begin
          pos_nxt = pos_r + 16'd1;
        end
      end
      default: begin
        // Sync hunt.
        if (sync1_r && (item_byte == SYNC_SECOND)) begin
          phase_nxt = PH_HEADER;
          pos_nxt   = HEADER_FIRST;
          sync1_nxt = 1'b0;
        end else begin
          phase_nxt = PH_HUNT;
          sync1_nxt = (item_byte == SYNC_FIRST);
        end
      end
    endcase
  end

  // A word without a result moves on even while the output is full.
  assign fire = item_valid && (out_free || !has_result);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= 16'd0;
      sync1_r <= 1'b0;
      high_r  <= 8'd0;
      hts_r   <= 16'd0;
      htp_r   <= 16'd0;
      hidx_r  <= 16'd0;
      hlen_r  <= 16'd0;
      fts_r   <= 16'd0;
      ftp_r   <= 16'd0;
      pr_r    <= 16'd0;
      br_r    <= 24'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sync1_r <= sync1_nxt;
      high_r  <= high_nxt;
      hts_r   <= hts_nxt;
      htp_r   <= htp_nxt;
      hidx_r  <= hidx_nxt;
      hlen_r  <= hlen_nxt;
      fts_r   <= fts_nxt;
      ftp_r   <= ftp_nxt;
      pr_r    <= pr_nxt;
      br_r    <= br_nxt;
    end
  end

  // Piece base address is registered after the multiplier; the piece index
  // settles two words before the header ends.
  always_ff @(posedge clk) begin
    base_r <= PROD_W'(hidx_r) * PIECE_BYTES_W;
    if (fire) begin
      addr_r <= addr_nxt;
    end
  end

endmodule

[rtl/core/prd_out_reg.sv]
// Result register that holds a word until the receiver takes it.
module prd_out_reg
  import prd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  prd_result_t result,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output prd_result_t held
);

  logic        valid_r;
  logic        valid_nxt;
  prd_result_t held_r;

  // Free when empty or when the held word leaves this cycle.
  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign held      = held_r;

endmodule
